FILE: hdl/hpi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hpi_pkg;

  localparam int unsigned COLOUR_W = 16;
  localparam int unsigned GEN_W    = 16;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned PROD_W   = 32;

  localparam logic [PROD_W-1:0] HASH_MULT  = 32'd2654435761;
  localparam int unsigned       HASH_SHIFT = 20;

  typedef struct packed {
    logic [GEN_W-1:0]    gen;
    logic [COLOUR_W-1:0] colour;
    logic [INDEX_W-1:0]  index;
  } hpi_entry_t;

endpackage

`default_nettype wire

FILE: hdl/hpi_hash.sv
`timescale 1ns / 1ps
`default_nettype none

module hpi_hash #(
  parameter int unsigned SLOT_W = 10
) (
  input  wire logic [hpi_pkg::COLOUR_W-1:0] colour_i,
  output logic      [SLOT_W-1:0]            slot_o
);
  import hpi_pkg::*;

  logic [PROD_W-1:0] prod;

  // multiplicative hash, SLOT_W bits of the product from bit HASH_SHIFT up
  assign prod   = {{(PROD_W-COLOUR_W){1'b0}}, colour_i} * HASH_MULT;
  assign slot_o = prod[HASH_SHIFT +: SLOT_W];

endmodule

`default_nettype wire

FILE: hdl/hash_palette_indexer_top.sv
// Palette indexer: maps each 16-bit pixel colour of a band to a palette index
// through an open-addressing hash table with linear probing.
// Input channel: colour_i and last_in_band_i under in_valid_i / in_ready_o.
// Output channel: palette_index_o, is_new_colour_o, overflowed_o,
// colours_so_far_o and band_done_o under out_valid_o / out_ready_i.
// One word is in flight at a time. Each probe reads one slot of the table
// memory, whose read is registered, one probe per cycle; usually the home
// slot alone is probed. Once a band has overflowed, no slot is probed.
// The result register loads at the edge that ends the last probe, or at the
// accepting edge itself once a band has overflowed.
// The result sits in an output register; a new word is accepted in the cycle
// the held result is taken, and a stalled receiver holds the block.
// After reset the table marks are cleared in a pass over every slot, during
// which no word is accepted; the same pass runs after the last word of a band
// when the generation counter wraps.
// The last word of a band ends the band: the palette count and the overflow
// flag return to zero and the generation advances.
`timescale 1ns / 1ps
`default_nettype none

module hash_palette_indexer_top #(
  parameter int unsigned TABLE_SLOTS = 1024,
  parameter int unsigned PALETTE_MAX = 256
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [hpi_pkg::COLOUR_W-1:0] colour_i,
  input  wire logic                         last_in_band_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [hpi_pkg::INDEX_W-1:0]  palette_index_o,
  output logic                              is_new_colour_o,
  output logic                              overflowed_o,
  output logic      [hpi_pkg::COUNT_W-1:0]  colours_so_far_o,
  output logic                              band_done_o
);
  import hpi_pkg::*;

  localparam int unsigned SLOT_W = $clog2(TABLE_SLOTS);
  localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(TABLE_SLOTS - 1);
  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(PALETTE_MAX);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_PROBE = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [SLOT_W-1:0]   clr_addr_q, clr_addr_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [SLOT_W-1:0]   probe_q, probe_d;
  logic [COLOUR_W-1:0] colour_q, colour_d;
  logic                last_q, last_d;
  logic [GEN_W-1:0]    gen_q, gen_d;
  logic [COUNT_W-1:0]  count_q, count_d;
  logic                ovf_q, ovf_d;

  logic                out_valid_q, out_valid_d;
  logic [INDEX_W-1:0]  out_index_q, out_index_d;
  logic                out_new_q, out_new_d;
  logic                out_ovf_q, out_ovf_d;
  logic [COUNT_W-1:0]  out_count_q, out_count_d;
  logic                out_done_q, out_done_d;

  hpi_entry_t          mem [TABLE_SLOTS];
  hpi_entry_t          rd_q;
  logic                mem_we, mem_re;
  logic [SLOT_W-1:0]   mem_waddr, mem_raddr;
  hpi_entry_t          mem_wdata;

  logic [SLOT_W-1:0]   hash_slot;
  logic                accept;
  logic                finish, finish_last;
  logic [INDEX_W-1:0]  f_index;
  logic                f_new, f_ovf;
  logic [COUNT_W-1:0]  f_count;

  hpi_hash #(
    .SLOT_W (SLOT_W)
  ) u_hash (
    .colour_i (colour_i),
    .slot_o   (hash_slot)
  );

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    slot_d      = slot_q;
    probe_d     = probe_q;
    colour_d    = colour_q;
    last_d      = last_q;
    gen_d       = gen_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_index_d = out_index_q;
    out_new_d   = out_new_q;
    out_ovf_d   = out_ovf_q;
    out_count_d = out_count_q;
    out_done_d  = out_done_q;
    mem_we      = 1'b0;
    mem_waddr   = clr_addr_q;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = hash_slot;
    finish      = 1'b0;
    finish_last = last_q;
    f_index     = '0;
    f_new       = 1'b0;
    f_ovf       = 1'b1;
    f_count     = count_q;

    case (state_q)
      ST_CLEAR: begin
        mem_we     = 1'b1;
        clr_addr_d = clr_addr_q + SLOT_W'(1);
        if (clr_addr_q == SLOT_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          colour_d = colour_i;
          last_d   = last_in_band_i;
          if (ovf_q) begin
            finish      = 1'b1;
            finish_last = last_in_band_i;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = hash_slot;
            slot_d    = hash_slot;
            probe_d   = '0;
            state_d   = ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        if (rd_q.gen != gen_q) begin
          finish  = 1'b1;
          state_d = ST_IDLE;
          if (count_q >= COUNT_MAX) begin
            ovf_d = 1'b1;
          end else begin
            mem_we           = 1'b1;
            mem_waddr        = slot_q;
            mem_wdata.gen    = gen_q;
            mem_wdata.colour = colour_q;
            mem_wdata.index  = count_q[INDEX_W-1:0];
            f_index          = count_q[INDEX_W-1:0];
            f_new            = 1'b1;
            f_ovf            = 1'b0;
            f_count          = count_q + COUNT_W'(1);
            count_d          = count_q + COUNT_W'(1);
          end
        end else if (rd_q.colour == colour_q) begin
          finish  = 1'b1;
          state_d = ST_IDLE;
          f_index = rd_q.index;
          f_ovf   = 1'b0;
        end else if (probe_q == SLOT_LAST) begin
          // whole table visited without a hit or a free slot
          finish  = 1'b1;
          state_d = ST_IDLE;
          ovf_d   = 1'b1;
        end else begin
          slot_d    = slot_q + SLOT_W'(1);
          probe_d   = probe_q + SLOT_W'(1);
          mem_re    = 1'b1;
          mem_raddr = slot_q + SLOT_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (finish) begin
      out_valid_d = 1'b1;
      out_index_d = f_index;
      out_new_d   = f_new;
      out_ovf_d   = f_ovf;
      out_count_d = f_count;
      out_done_d  = finish_last;
      if (finish_last) begin
        count_d = '0;
        ovf_d   = 1'b0;
        gen_d   = gen_q + GEN_W'(1);
        if (gen_q == '1) begin
          gen_d      = GEN_W'(1);
          clr_addr_d = '0;
          state_d    = ST_CLEAR;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      gen_q       <= GEN_W'(1);
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      gen_q       <= gen_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q      <= slot_d;
    probe_q     <= probe_d;
    colour_q    <= colour_d;
    last_q      <= last_d;
    out_index_q <= out_index_d;
    out_new_q   <= out_new_d;
    out_ovf_q   <= out_ovf_d;
    out_count_q <= out_count_d;
    out_done_q  <= out_done_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign palette_index_o  = out_index_q;
  assign is_new_colour_o  = out_new_q;
  assign overflowed_o     = out_ovf_q;
  assign colours_so_far_o = out_count_q;
  assign band_done_o      = out_done_q;

endmodule

`default_nettype wire

FILE: tb/sv/hash_palette_indexer_top_tb.sv
`timescale 1ns / 1ps

module hash_palette_indexer_top_tb;

  localparam int unsigned TABLE_SLOTS   = 1024;
  localparam int unsigned PALETTE_MAX   = 256;
  localparam int          RANDOM_WORDS  = 1950;
  localparam int          DIRECTED_ROWS = 17;
  localparam int          DRAIN_CYCLES  = 16;

  typedef struct packed {
    logic [hpi_pkg::INDEX_W-1:0] palette_index;
    logic                        is_new_colour;
    logic                        overflowed;
    logic [hpi_pkg::COUNT_W-1:0] colours_so_far;
    logic                        band_done;
  } palette_result_t;

  typedef enum logic {SRC_LITERAL, SRC_CLUSTER} colour_src_e;

  typedef enum logic [1:0] {
    BAND_PALETTE,
    BAND_CLUSTER,
    BAND_WIDE,
    BAND_OVERFLOW
  } band_kind_e;

  typedef struct {
    colour_src_e                  src;
    logic [hpi_pkg::COLOUR_W-1:0] colour;
    logic                         last;
    bit                           typed;
    palette_result_t              result;
  } stim_row_t;

  logic                          clk_i          = 1'b0;
  logic                          rst_ni         = 1'b0;
  logic                          in_valid_i     = 1'b0;
  logic                          in_ready_o;
  logic [hpi_pkg::COLOUR_W-1:0]  colour_i       = '0;
  logic                          last_in_band_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_ready_i    = 1'b0;
  logic [hpi_pkg::INDEX_W-1:0]   palette_index_o;
  logic                          is_new_colour_o;
  logic                          overflowed_o;
  logic [hpi_pkg::COUNT_W-1:0]   colours_so_far_o;
  logic                          band_done_o;

  // palette table model
  logic [hpi_pkg::COLOUR_W-1:0]  tbl_colour [TABLE_SLOTS];
  logic [hpi_pkg::GEN_W-1:0]     tbl_mark   [TABLE_SLOTS];
  logic [hpi_pkg::INDEX_W-1:0]   tbl_entry  [TABLE_SLOTS];
  logic [hpi_pkg::GEN_W-1:0]     cur_generation = 16'd1;
  logic [hpi_pkg::COUNT_W-1:0]   palette_count  = '0;
  logic                          band_overflow  = 1'b0;

  palette_result_t               pending_results [$];
  logic [hpi_pkg::COLOUR_W-1:0]  cluster_colours [$];

  bit  in_idle_en   = 1'b0;
  bit  out_stall_en = 1'b0;
  int  out_stall_left = 0;
  int  words_sent   = 0;
  int  bands_sent   = 0;
  int  wraps_seen   = 0;
  int  new_colours  = 0;
  int  overflow_results = 0;
  int  mismatches   = 0;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{SRC_LITERAL, 16'h0000, 1'b0, 1'b1, '{8'd0, 1'b1, 1'b0, 9'd1, 1'b0}},
    '{SRC_LITERAL, 16'hFFFF, 1'b0, 1'b1, '{8'd1, 1'b1, 1'b0, 9'd2, 1'b0}},
    '{SRC_LITERAL, 16'h0000, 1'b0, 1'b1, '{8'd0, 1'b0, 1'b0, 9'd2, 1'b0}},
    '{SRC_LITERAL, 16'hFFFF, 1'b1, 1'b1, '{8'd1, 1'b0, 1'b0, 9'd2, 1'b1}},
    '{SRC_LITERAL, 16'hFFFF, 1'b0, 1'b1, '{8'd0, 1'b1, 1'b0, 9'd1, 1'b0}},
    '{SRC_CLUSTER, 16'd0,    1'b0, 1'b0, '0},
    '{SRC_CLUSTER, 16'd1,    1'b0, 1'b0, '0},
    '{SRC_CLUSTER, 16'd2,    1'b0, 1'b0, '0},
    '{SRC_CLUSTER, 16'd3,    1'b0, 1'b0, '0},
    '{SRC_CLUSTER, 16'd1,    1'b0, 1'b0, '0},
    '{SRC_CLUSTER, 16'd3,    1'b0, 1'b0, '0},
    '{SRC_CLUSTER, 16'd0,    1'b1, 1'b0, '0},
    '{SRC_LITERAL, 16'h1234, 1'b1, 1'b1, '{8'd0, 1'b1, 1'b0, 9'd1, 1'b1}},
    '{SRC_LITERAL, 16'h8000, 1'b0, 1'b0, '0},
    '{SRC_LITERAL, 16'h5555, 1'b0, 1'b0, '0},
    '{SRC_LITERAL, 16'hAAAA, 1'b0, 1'b0, '0},
    '{SRC_LITERAL, 16'h8000, 1'b1, 1'b0, '0}
  };

  hash_palette_indexer_top #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .PALETTE_MAX (PALETTE_MAX)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .colour_i         (colour_i),
    .last_in_band_i   (last_in_band_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .palette_index_o  (palette_index_o),
    .is_new_colour_o  (is_new_colour_o),
    .overflowed_o     (overflowed_o),
    .colours_so_far_o (colours_so_far_o),
    .band_done_o      (band_done_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned home_slot(input logic [hpi_pkg::COLOUR_W-1:0] c);
    logic [hpi_pkg::PROD_W-1:0] prod;
    prod = {16'd0, c} * hpi_pkg::HASH_MULT;
    return (prod >> hpi_pkg::HASH_SHIFT) & (TABLE_SLOTS - 1);
  endfunction

  function automatic palette_result_t index_colour(input logic [hpi_pkg::COLOUR_W-1:0] c,
                                                   input logic last);
    palette_result_t r;
    int unsigned     slot;
    bit              found;
    r     = '0;
    found = 1'b0;
    if (!band_overflow) begin
      slot = home_slot(c);
      for (int p = 0; p < TABLE_SLOTS && !found; p++) begin
        if (tbl_mark[slot] != cur_generation) begin
          if (palette_count >= PALETTE_MAX) begin
            band_overflow = 1'b1;
          end else begin
            tbl_mark[slot]   = cur_generation;
            tbl_colour[slot] = c;
            tbl_entry[slot]  = palette_count[hpi_pkg::INDEX_W-1:0];
            r.palette_index  = palette_count[hpi_pkg::INDEX_W-1:0];
            r.is_new_colour  = 1'b1;
            palette_count    = palette_count + 1'b1;
          end
          found = 1'b1;
        end else if (tbl_colour[slot] == c) begin
          r.palette_index = tbl_entry[slot];
          found = 1'b1;
        end else begin
          slot = (slot + 1) % TABLE_SLOTS;
        end
      end
      if (!found) begin
        band_overflow = 1'b1;
      end
    end
    if (band_overflow) begin
      r.palette_index = '0;
      r.is_new_colour = 1'b0;
    end
    r.overflowed     = band_overflow;
    r.colours_so_far = palette_count;
    r.band_done      = last;
    if (last) begin
      palette_count  = '0;
      band_overflow  = 1'b0;
      cur_generation = cur_generation + 16'd1;
      if (cur_generation == '0) begin
        foreach (tbl_mark[i]) tbl_mark[i] = '0;
        cur_generation = 16'd1;
        wraps_seen++;
      end
    end
    return r;
  endfunction

  task automatic drive_word(input logic [hpi_pkg::COLOUR_W-1:0] c, input logic last);
    if (in_idle_en && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    colour_i       <= c;
    last_in_band_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  task automatic send_word(input logic [hpi_pkg::COLOUR_W-1:0] c, input logic last);
    pending_results.push_back(index_colour(c, last));
    drive_word(c, last);
  endtask

  task automatic send_band(input band_kind_e kind);
    logic [hpi_pkg::COLOUR_W-1:0] pool [$];
    int unsigned                  len;
    int unsigned                  reuse;
    logic [hpi_pkg::COLOUR_W-1:0] c;
    reuse = 0;
    case (kind)
      BAND_PALETTE: begin
        len = $urandom_range(1, 40);
        repeat ($urandom_range(1, 16)) pool.push_back(16'($urandom));
      end
      BAND_CLUSTER: begin
        len = $urandom_range(1, 40);
        repeat ($urandom_range(2, 24)) begin
          pool.push_back(cluster_colours[$urandom_range(0, cluster_colours.size() - 1)]);
        end
      end
      BAND_WIDE: begin
        len   = $urandom_range(1, 60);
        reuse = 3;
      end
      default: begin
        len   = $urandom_range(270, 330);
        reuse = 1;
      end
    endcase
    for (int i = 0; i < len; i++) begin
      if (kind == BAND_PALETTE || kind == BAND_CLUSTER) begin
        c = pool[$urandom_range(0, pool.size() - 1)];
      end else if (pool.size() != 0 && $urandom_range(0, 9) < reuse) begin
        c = pool[$urandom_range(0, pool.size() - 1)];
      end else begin
        c = 16'($urandom);
        pool.push_back(c);
      end
      if ($urandom_range(0, 49) == 0) begin
        c = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      end
      send_word(c, i == len - 1);
    end
    bands_sent++;
  endtask

  // receiver stalls
  always @(posedge clk_i) begin
    if (out_stall_left != 0) begin
      out_stall_left <= out_stall_left - 1;
      if (out_stall_left == 1) begin
        out_ready_i <= 1'b1;
      end
    end else if (rst_ni && out_stall_en && $urandom_range(0, 7) == 0) begin
      out_stall_left <= $urandom_range(1, 12);
      out_ready_i    <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    palette_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (is_new_colour_o) new_colours++;
      if (overflowed_o) overflow_results++;
      if (pending_results.size() == 0) begin
        $error("result word with nothing pending: palette_index %0d", palette_index_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (palette_index_o !== want.palette_index) begin
          $error("palette_index expected %0d actual %0d", want.palette_index, palette_index_o);
          mismatches++;
        end
        if (is_new_colour_o !== want.is_new_colour) begin
          $error("is_new_colour expected %0d actual %0d", want.is_new_colour, is_new_colour_o);
          mismatches++;
        end
        if (overflowed_o !== want.overflowed) begin
          $error("overflowed expected %0d actual %0d", want.overflowed, overflowed_o);
          mismatches++;
        end
        if (colours_so_far_o !== want.colours_so_far) begin
          $error("colours_so_far expected %0d actual %0d", want.colours_so_far,
                 colours_so_far_o);
          mismatches++;
        end
        if (band_done_o !== want.band_done) begin
          $error("band_done expected %0d actual %0d", want.band_done, band_done_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("hash_palette_indexer_top_tb failed");
    $finish;
  end

  initial begin
    palette_result_t  r;
    logic [hpi_pkg::COLOUR_W-1:0] c;
    band_kind_e       kind;
    int               band_no;
    band_no = 0;
    foreach (tbl_mark[i]) begin
      tbl_mark[i]   = '0;
      tbl_colour[i] = '0;
      tbl_entry[i]  = '0;
    end
    // colours homing on the last slots, so probing wraps to slot 0
    for (int v = 0; v < 65536; v++) begin
      if (home_slot(16'(v)) >= TABLE_SLOTS - 2) cluster_colours.push_back(16'(v));
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    in_idle_en   = 1'b1;
    out_stall_en = 1'b1;
    foreach (directed_rows[k]) begin
      c = (directed_rows[k].src == SRC_CLUSTER) ?
          cluster_colours[directed_rows[k].colour] : directed_rows[k].colour;
      r = index_colour(c, directed_rows[k].last);
      pending_results.push_back(directed_rows[k].typed ? directed_rows[k].result : r);
      drive_word(c, directed_rows[k].last);
    end
    bands_sent += 4;

    while (words_sent < DIRECTED_ROWS + RANDOM_WORDS) begin
      band_no++;
      in_idle_en   = ($urandom_range(0, 3) != 0);
      out_stall_en = ($urandom_range(0, 3) != 0);
      if (band_no % 8 == 3) begin
        kind = BAND_OVERFLOW;
      end else begin
        case ($urandom_range(0, 2))
          0:       kind = BAND_PALETTE;
          1:       kind = BAND_CLUSTER;
          default: kind = BAND_WIDE;
        endcase
      end
      send_band(kind);
    end

    // back-to-back bands with no idling, then reuse old colours
    in_idle_en   = 1'b0;
    out_stall_en = 1'b0;
    repeat (3) send_band(BAND_PALETTE);
    send_word(16'h0000, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(cluster_colours[0], 1'b0);
    send_word(cluster_colours[1], 1'b0);
    send_word(cluster_colours[0], 1'b1);
    bands_sent++;
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d words in %0d bands, %0d palette appends, %0d overflowed words",
             words_sent, bands_sent, new_colours, overflow_results);
    $display("generation wraps seen: %0d, field mismatches: %0d", wraps_seen, mismatches);
    if (mismatches == 0) begin
      $display("hash_palette_indexer_top_tb passed");
    end else begin
      $display("hash_palette_indexer_top_tb failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/hpi_pkg.sv
hdl/hpi_hash.sv
hdl/hash_palette_indexer_top.sv
tb/sv/hash_palette_indexer_top_tb.sv
